[rtl/rrs_pkg.sv]
// Shared types, constants and helpers for the round-robin scheduler.
// No dependencies; imported by every rrs module and the top level.
package rrs_pkg;

    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [Q_AW-1:0] t_qptr;
    typedef logic [Q_CW-1:0] t_qcnt;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_RAN   = 3'd1,
        ST_WAIT  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] arr;
        logic [15:0] bur;
        logic [15:0] done;
    } t_entry;

    typedef struct packed {
        logic   pop;
        logic   push;
        t_entry wr_entry;
    } t_qctrl;

    typedef struct packed {
        t_status     status;
        logic [15:0] job_id;
        logic [7:0]  run_time;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] sum_turnaround;
        logic [31:0] sum_waiting;
        logic [31:0] finished_count;
    } t_result;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[rtl/rrs_queue.sv]
// Circular ready queue: entry storage, head/tail pointers and fill count.
// Depends on rrs_pkg.
module rrs_queue import rrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qctrl i_ctrl,
    output t_entry o_head_entry,
    output t_qcnt  o_count
);

    t_entry r_mem [Q_DEPTH];
    t_qptr  r_head, n_head;
    t_qptr  r_tail, n_tail;
    t_qcnt  r_count, n_count;

    function automatic t_qptr ptr_inc(input t_qptr p);
        return (p == t_qptr'(Q_DEPTH - 1)) ? '0 : p + t_qptr'(1);
    endfunction

    always_comb begin
        n_head  = i_ctrl.pop  ? ptr_inc(r_head) : r_head;
        n_tail  = i_ctrl.push ? ptr_inc(r_tail) : r_tail;
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + t_qcnt'(1);
        end else if (!i_ctrl.push && i_ctrl.pop) begin
            n_count = r_count - t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_ctrl.wr_entry;
        end
    end

    assign o_head_entry = r_mem[r_head];
    assign o_count      = r_count;

endmodule

[rtl/rrs_exec.sv]
// Slice execution: job numbering, tick counter, quantum and running totals.
// Depends on rrs_pkg; drives the queue control of rrs_queue.
module rrs_exec import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_fire,
    input  logic        i_action,
    input  logic [15:0] i_burst,
    input  logic [15:0] i_arrival,
    input  t_entry      i_head_entry,
    input  t_qcnt       i_count,
    output t_qctrl      o_qctrl,
    output t_result     o_result
);

    logic [7:0]  r_quantum;
    logic [31:0] r_tick,      n_tick;
    logic [15:0] r_next_job,  n_next_job;
    logic [31:0] r_sum_t,     n_sum_t;
    logic [31:0] r_sum_w,     n_sum_w;
    logic [31:0] r_done_cnt,  n_done_cnt;

    logic [7:0]  w_q;
    logic [15:0] w_rem;
    logic [7:0]  w_run;
    logic [31:0] w_tick_run;
    logic [15:0] w_done_new;
    logic [31:0] w_tat;
    logic [31:0] w_wt;
    logic [15:0] w_new_id;

    assign w_q        = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign w_rem      = (i_head_entry.bur > i_head_entry.done)
                      ? i_head_entry.bur - i_head_entry.done : 16'd0;
    assign w_run      = ({8'd0, w_q} < w_rem) ? w_q : w_rem[7:0];
    assign w_tick_run = sat_add32(r_tick, {24'd0, w_run});
    assign w_done_new = i_head_entry.done + {8'd0, w_run};
    assign w_tat      = w_tick_run - {16'd0, i_head_entry.arr};
    assign w_wt       = (w_tat > {16'd0, i_head_entry.bur})
                      ? w_tat - {16'd0, i_head_entry.bur} : 32'd0;
    assign w_new_id   = r_next_job + 16'd1;

    always_comb begin
        n_tick     = r_tick;
        n_next_job = r_next_job;
        n_sum_t    = r_sum_t;
        n_sum_w    = r_sum_w;
        n_done_cnt = r_done_cnt;
        o_qctrl    = '0;
        o_result   = '0;
        o_result.status = ST_EMPTY;
        if (i_action == ACT_ADD) begin
            if (i_count == t_qcnt'(Q_DEPTH)) begin
                o_result.status = ST_FULL;
            end else begin
                n_next_job                = w_new_id;
                o_result.status           = ST_ADDED;
                o_result.job_id           = w_new_id;
                o_qctrl.push              = i_fire;
                o_qctrl.wr_entry.id       = w_new_id;
                o_qctrl.wr_entry.arr      = i_arrival;
                o_qctrl.wr_entry.bur      = i_burst;
                o_qctrl.wr_entry.done     = 16'd0;
            end
        end else if (i_count != '0) begin
            o_qctrl.pop     = i_fire;
            o_result.job_id = i_head_entry.id;
            if ({16'd0, i_head_entry.arr} > r_tick) begin
                o_result.status  = ST_WAIT;
                o_qctrl.push     = i_fire;
                o_qctrl.wr_entry = i_head_entry;
            end else begin
                o_result.status   = ST_RAN;
                o_result.run_time = w_run;
                n_tick            = w_tick_run;
                if (w_done_new < i_head_entry.bur) begin
                    o_qctrl.push          = i_fire;
                    o_qctrl.wr_entry      = i_head_entry;
                    o_qctrl.wr_entry.done = w_done_new;
                end else begin
                    o_result.finished   = 1'b1;
                    o_result.turnaround = w_tat;
                    o_result.waiting    = w_wt;
                    n_sum_t             = sat_add32(r_sum_t, w_tat);
                    n_sum_w             = sat_add32(r_sum_w, w_wt);
                    n_done_cnt          = sat_add32(r_done_cnt, 32'd1);
                    // last job left the queue
                    if (i_count == t_qcnt'(1)) begin
                        n_tick = 32'd0;
                    end
                end
            end
        end
        o_result.sum_turnaround = n_sum_t;
        o_result.sum_waiting    = n_sum_w;
        o_result.finished_count = n_done_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum  <= 8'd1;
            r_tick     <= '0;
            r_next_job <= '0;
            r_sum_t    <= '0;
            r_sum_w    <= '0;
            r_done_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
            if (i_fire) begin
                r_tick     <= n_tick;
                r_next_job <= n_next_job;
                r_sum_t    <= n_sum_t;
                r_sum_w    <= n_sum_w;
                r_done_cnt <= n_done_cnt;
            end
        end
    end

endmodule

[rtl/round_robin_scheduler.sv]
// Round-robin time-slice scheduler: takes add and dispatch commands and returns
// one result per command. An accepted command is registered, then processed
// against the 16-entry ready queue and the counters once the output register
// can take its result, and its result lands in that output register; a new
// command can be taken every cycle, so throughput is one command per cycle while
// the result side keeps up. The quantum is written over the config channel,
// which is always ready; write it only while no command is in flight.
// Depends on rrs_pkg, rrs_queue and rrs_exec.
module round_robin_scheduler import rrs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write: quantum
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,
    // command stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // burst[15:0], arrival_time[31:16]
    input  logic         i_s_axis_tuser,   // action
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [191:0] o_m_axis_tdata,   // job_id, run_time, finished, turnaround,
                                           // waiting, sum_turnaround, sum_waiting,
                                           // finished_count, zero pad
    output logic [2:0]   o_m_axis_tuser    // status
);

    logic        r_in_valid;
    logic        r_action;
    logic [15:0] r_burst;
    logic [15:0] r_arrival;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_fire;
    t_qctrl      w_qctrl;
    t_entry      w_head_entry;
    t_qcnt       w_count;
    t_result     w_result;

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign o_cfg_ready     = 1'b1;

    rrs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_qctrl),
        .o_head_entry (w_head_entry),
        .o_count      (w_count)
    );

    rrs_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (w_fire),
        .i_action     (r_action),
        .i_burst      (r_burst),
        .i_arrival    (r_arrival),
        .i_head_entry (w_head_entry),
        .i_count      (w_count),
        .o_qctrl      (w_qctrl),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_action  <= i_s_axis_tuser;
            r_burst   <= i_s_axis_tdata[15:0];
            r_arrival <= i_s_axis_tdata[31:16];
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {7'd0,
                              r_out.finished_count,
                              r_out.sum_waiting,
                              r_out.sum_turnaround,
                              r_out.waiting,
                              r_out.turnaround,
                              r_out.finished,
                              r_out.run_time,
                              r_out.job_id};

endmodule
